// ----- design/fla_pkg.sv -----
// Package for the free list heap allocator: header word layout, memory request
// struct, result struct, sequencer states and fixed sizes.
// Depends on nothing; every other design file imports it.
`default_nettype none
package fla_pkg;

    localparam int HEAP_UNITS = 4096;
    localparam int UNIT_BYTES = 16;
    localparam int UB_SHIFT   = $clog2(UNIT_BYTES);
    localparam int UW         = $clog2(HEAP_UNITS);
    localparam int SW         = UW + 1;
    localparam int XW         = UW + 2;
    localparam int NB_W       = 16;
    localparam int CFG_W      = 12;
    localparam int STEP_W     = 14;
    localparam int WALK_LIMIT = 3 * HEAP_UNITS + 8;
    localparam int GROW_RESET = 1024;

    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_FREE   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    typedef struct packed {
        logic [UW-1:0] link;
        logic [SW-1:0] size;
    } hdr_word_t;

    typedef struct packed {
        logic          we_link;
        logic          we_size;
        logic [UW-1:0] addr;
        hdr_word_t     wdata;
    } hdr_req_t;

    typedef struct packed {
        logic          status;
        logic [UW-1:0] addr_out;
    } fla_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_INIT,
        ST_A_START,
        ST_A_LINK,
        ST_A_CHECK,
        ST_A_SPLIT,
        ST_R_START,
        ST_R_WALK,
        ST_R_HB,
        ST_R_Q,
        ST_R_RDP,
        ST_R_P,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- design/fla_hdr_ram.sv -----
// Header memory: one next link and one block size per heap unit.
// Single port, separate field write enables, registered read. Uses fla_pkg.
`default_nettype none
module fla_hdr_ram (
    input  wire logic              aclk,
    input  wire fla_pkg::hdr_req_t req,
    output fla_pkg::hdr_word_t     rdata
);
    import fla_pkg::*;

    hdr_word_t mem_array [HEAP_UNITS];

    always_ff @(posedge aclk) begin
        if (req.we_link) begin
            mem_array[req.addr].link <= req.wdata.link;
        end
        if (req.we_size) begin
            mem_array[req.addr].size <= req.wdata.size;
        end
        rdata <= mem_array[req.addr];
    end

endmodule
`default_nettype wire

// ----- design/fla_ctrl.sv -----
// Allocator sequencer: walks the free list, splits, grows the heap and
// inserts freed blocks with merging. Drives fla_hdr_ram; uses fla_pkg.
`default_nettype none
module fla_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire logic                  req_type,
    input  wire logic [15:0]           nbytes,
    input  wire logic [11:0]           addr,
    input  wire logic [11:0]           grow_chunk,
    input  wire logic                  out_free,
    output logic                       res_load,
    output fla_pkg::fla_res_t          res,
    output fla_pkg::hdr_req_t          mem_req,
    input  wire fla_pkg::hdr_word_t    mem_rdata
);
    import fla_pkg::*;

    state_t            state_reg, state_next;
    logic [UW-1:0]     rover_reg, rover_next;
    logic              ready_reg, ready_next;
    logic [SW-1:0]     bp_reg, bp_next;

    logic [SW-1:0]     need_reg, need_next;
    logic [UW-1:0]     prev_reg, prev_next;
    logic [UW-1:0]     p_reg, p_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              regrow_reg, regrow_next;
    logic [XW-1:0]     split_reg, split_next;
    logic [UW-1:0]     hb_reg, hb_next;
    logic [UW-1:0]     rp_reg, rp_next;
    logic [UW-1:0]     q_reg, q_next;
    logic [SW-1:0]     hbsz_reg, hbsz_next;
    logic [UW-1:0]     hblink_reg, hblink_next;
    logic [STEP_W-1:0] rsteps_reg, rsteps_next;
    logic              from_grow_reg, from_grow_next;
    fla_res_t          res_reg, res_next;

    logic [NB_W-1:0]   nb_one;
    logic [NB_W:0]     nb_sum;
    logic [SW-1:0]     need_calc;
    logic [STEP_W-1:0] steps_inc;
    logic [STEP_W-1:0] rsteps_inc;
    logic [SW-1:0]     grow;
    logic [XW-1:0]     grow_top;
    logic [SW-1:0]     size_diff;
    logic              found;

    assign nb_one    = (nbytes == '0) ? NB_W'(1) : nbytes;
    assign nb_sum    = {1'b0, nb_one} + (NB_W+1)'(UNIT_BYTES - 1);
    assign need_calc = SW'(nb_sum >> UB_SHIFT) + SW'(1);
    assign steps_inc = steps_reg + STEP_W'(1);
    assign rsteps_inc = rsteps_reg + STEP_W'(1);
    assign grow      = (need_reg < {1'b0, grow_chunk}) ? {1'b0, grow_chunk} : need_reg;
    assign grow_top  = {1'b0, bp_reg} + {1'b0, grow};
    assign size_diff = mem_rdata.size - need_reg;
    assign found     = (hb_reg > rp_reg && hb_reg < mem_rdata.link) ||
                       (rp_reg >= mem_rdata.link &&
                        (hb_reg > rp_reg || hb_reg < mem_rdata.link));
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rover_reg <= '0;
            ready_reg <= 1'b0;
            bp_reg    <= SW'(1);
        end else begin
            state_reg <= state_next;
            rover_reg <= rover_next;
            ready_reg <= ready_next;
            bp_reg    <= bp_next;
        end
    end

    always_ff @(posedge aclk) begin
        need_reg      <= need_next;
        prev_reg      <= prev_next;
        p_reg         <= p_next;
        steps_reg     <= steps_next;
        regrow_reg    <= regrow_next;
        split_reg     <= split_next;
        hb_reg        <= hb_next;
        rp_reg        <= rp_next;
        q_reg         <= q_next;
        hbsz_reg      <= hbsz_next;
        hblink_reg    <= hblink_next;
        rsteps_reg    <= rsteps_next;
        from_grow_reg <= from_grow_next;
        res_reg       <= res_next;
    end

    always_comb begin
        state_next     = state_reg;
        rover_next     = rover_reg;
        ready_next     = ready_reg;
        bp_next        = bp_reg;
        need_next      = need_reg;
        prev_next      = prev_reg;
        p_next         = p_reg;
        steps_next     = steps_reg;
        regrow_next    = regrow_reg;
        split_next     = split_reg;
        hb_next        = hb_reg;
        rp_next        = rp_reg;
        q_next         = q_reg;
        hbsz_next      = hbsz_reg;
        hblink_next    = hblink_reg;
        rsteps_next    = rsteps_reg;
        from_grow_next = from_grow_reg;
        res_next       = res_reg;
        mem_req        = '0;
        req_ready      = 1'b0;
        res_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    res_next = '{status: STATUS_OK, addr_out: '0};
                    if (req_type == REQ_ALLOC) begin
                        need_next   = need_calc;
                        steps_next  = '0;
                        regrow_next = 1'b0;
                        state_next  = ready_reg ? ST_A_START : ST_A_INIT;
                    end else begin
                        from_grow_next = 1'b0;
                        if (ready_reg && addr >= UW'(2) &&
                            {1'b0, addr - UW'(1)} < bp_reg) begin
                            hb_next    = addr - UW'(1);
                            state_next = ST_R_START;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_A_INIT: begin
                mem_req.we_link = 1'b1;
                mem_req.we_size = 1'b1;
                rover_next      = '0;
                ready_next      = 1'b1;
                state_next      = ST_A_START;
            end
            ST_A_START: begin
                mem_req.addr = rover_reg;
                state_next   = ST_A_LINK;
            end
            ST_A_LINK: begin
                prev_next = rover_reg;
                p_next    = mem_rdata.link;
                if (regrow_reg) begin
                    steps_next = steps_inc;
                end
                if (regrow_reg && steps_inc > STEP_W'(WALK_LIMIT)) begin
                    res_next   = '{status: STATUS_OOM, addr_out: '0};
                    state_next = ST_DONE;
                end else begin
                    mem_req.addr = mem_rdata.link;
                    state_next   = ST_A_CHECK;
                end
            end
            ST_A_CHECK: begin
                if (mem_rdata.size >= need_reg) begin
                    rover_next = prev_reg;
                    if (mem_rdata.size == need_reg) begin
                        mem_req.we_link    = 1'b1;
                        mem_req.addr       = prev_reg;
                        mem_req.wdata.link = mem_rdata.link;
                        res_next   = '{status: STATUS_OK, addr_out: p_reg + UW'(1)};
                        state_next = ST_DONE;
                    end else begin
                        mem_req.we_size    = 1'b1;
                        mem_req.addr       = p_reg;
                        mem_req.wdata.size = size_diff;
                        split_next = {2'b00, p_reg} + {1'b0, size_diff};
                        state_next = ST_A_SPLIT;
                    end
                end else if (p_reg == rover_reg) begin
                    if (grow_top > XW'(HEAP_UNITS)) begin
                        res_next   = '{status: STATUS_OOM, addr_out: '0};
                        state_next = ST_DONE;
                    end else begin
                        bp_next            = grow_top[SW-1:0];
                        mem_req.we_size    = 1'b1;
                        mem_req.addr       = bp_reg[UW-1:0];
                        mem_req.wdata.size = grow;
                        hb_next            = bp_reg[UW-1:0];
                        from_grow_next     = 1'b1;
                        state_next         = ST_R_START;
                    end
                end else begin
                    prev_next  = p_reg;
                    p_next     = mem_rdata.link;
                    steps_next = steps_inc;
                    if (steps_inc > STEP_W'(WALK_LIMIT)) begin
                        res_next   = '{status: STATUS_OOM, addr_out: '0};
                        state_next = ST_DONE;
                    end else begin
                        mem_req.addr = mem_rdata.link;
                    end
                end
            end
            ST_A_SPLIT: begin
                if (split_reg < XW'(HEAP_UNITS)) begin
                    mem_req.we_size    = 1'b1;
                    mem_req.addr       = split_reg[UW-1:0];
                    mem_req.wdata.size = need_reg;
                end
                res_next   = '{status: STATUS_OK, addr_out: split_reg[UW-1:0] + UW'(1)};
                state_next = ST_DONE;
            end
            ST_R_START: begin
                rp_next      = rover_reg;
                rsteps_next  = '0;
                mem_req.addr = rover_reg;
                state_next   = ST_R_WALK;
            end
            ST_R_WALK: begin
                if (found) begin
                    q_next       = mem_rdata.link;
                    mem_req.addr = hb_reg;
                    state_next   = ST_R_HB;
                end else begin
                    rsteps_next = rsteps_inc;
                    if (rsteps_inc > STEP_W'(WALK_LIMIT)) begin
                        regrow_next = 1'b1;
                        state_next  = from_grow_reg ? ST_A_START : ST_DONE;
                    end else begin
                        rp_next      = mem_rdata.link;
                        mem_req.addr = mem_rdata.link;
                    end
                end
            end
            ST_R_HB: begin
                hbsz_next    = mem_rdata.size;
                mem_req.addr = q_reg;
                state_next   = ST_R_Q;
            end
            ST_R_Q: begin
                mem_req.addr    = hb_reg;
                mem_req.we_link = 1'b1;
                if ({2'b00, hb_reg} + {1'b0, hbsz_reg} == {2'b00, q_reg}) begin
                    mem_req.we_size    = 1'b1;
                    mem_req.wdata.size = hbsz_reg + mem_rdata.size;
                    mem_req.wdata.link = mem_rdata.link;
                    hbsz_next          = hbsz_reg + mem_rdata.size;
                    hblink_next        = mem_rdata.link;
                end else begin
                    mem_req.wdata.link = q_reg;
                    hblink_next        = q_reg;
                end
                state_next = ST_R_RDP;
            end
            ST_R_RDP: begin
                mem_req.addr = rp_reg;
                state_next   = ST_R_P;
            end
            ST_R_P: begin
                mem_req.addr    = rp_reg;
                mem_req.we_link = 1'b1;
                if ({2'b00, rp_reg} + {1'b0, mem_rdata.size} == {2'b00, hb_reg}) begin
                    mem_req.we_size    = 1'b1;
                    mem_req.wdata.size = mem_rdata.size + hbsz_reg;
                    mem_req.wdata.link = hblink_reg;
                end else begin
                    mem_req.wdata.link = hb_reg;
                end
                rover_next  = rp_reg;
                regrow_next = 1'b1;
                state_next  = from_grow_reg ? ST_A_START : ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/free_list_heap_allocator_unit.sv -----
// An allocate walks the free list block by block, with an extra step for a split and a
// list setup step on the first allocate after reset; each heap growth writes the new
// region and inserts it into the list as a free does. A free walks the list to find its
// place and merges with its neighbours. All header traffic shares the single port of the
// header memory. One request at a time: the next is accepted the cycle after the result
// is loaded, and a result that is not taken holds the sequencer.
// Reset clears the sequencer, rover, list setup flag and output valid, sets the break point
// to 1 and the grow_chunk register to 1024; the header memory is not cleared.
`default_nettype none
module free_list_heap_allocator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [15:0] s_nbytes,
    input  wire logic [11:0] s_addr,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic [11:0]      m_addr_out,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata
);
    import fla_pkg::*;

    logic [CFG_W-1:0] grow_chunk_reg;
    logic             m_valid_reg;
    fla_res_t         out_reg;
    logic             out_free;
    logic             res_load;
    fla_res_t         res;
    hdr_req_t         mem_req;
    hdr_word_t        mem_rdata;

    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_status   = out_reg.status;
    assign m_addr_out = out_reg.addr_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grow_chunk_reg <= CFG_W'(GROW_RESET);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                grow_chunk_reg <= cfg_wdata;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res;
        end
    end

    fla_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .req_type   (s_req_type),
        .nbytes     (s_nbytes),
        .addr       (s_addr),
        .grow_chunk (grow_chunk_reg),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    fla_hdr_ram u_hdr_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer took a request while busy");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> out_free)
        else $error("result loaded over a pending result");

    a_oom_has_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_addr_out == '0)
        else $error("failed allocate returned a nonzero address");

endmodule
`default_nettype wire
